### hw/rtl/wsp_pkg.sv
package wsp_pkg;

    localparam int MAX_ELEMENTS = 16;
    // Count runs 0..MAX_ELEMENTS inclusive
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    // Index of one element cell
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] STAR_CHAR = 8'h2A;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } t_action;

    // Per-cell control, driven by the top level every cycle
    typedef struct packed {
        logic       clr;       // drop the element
        logic       wr;        // load a new element into this cell
        logic       star_set;  // mark this element as starred
        logic       step;      // advance the NFA by one subject byte
        logic       open;      // a subject is in progress
        logic [7:0] chr;       // pattern or subject byte
    } t_cell_ctrl;

endpackage

### hw/rtl/wildcard_star_pattern_matcher.sv
// An accepted end-of-subject transfer shows its verdict on the master side in the next cycle.
// Throughput: one input transfer per cycle for every action while no undrained verdict stalls input;
//   subject bytes at one per cycle, bounded by the ripple of the closure chain across the cell row.
// Reset: synchronous, active low; empties the pattern, clears overflow, closes the
//   subject and drops any pending verdict. Element bytes are not reset.
module wildcard_star_pattern_matcher
    import wsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] character
    input  logic [1:0] s_axis_tuser,   // [1:0] action
    // verdict stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
    output logic       m_axis_tuser    // [0] overflow
);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             r_open, n_open;
    logic             r_act_end, n_act_end;   // NFA position past the last cell
    logic             r_out_valid, n_out_valid;
    logic             r_out_matched, n_out_matched;
    logic             r_out_ovf, n_out_ovf;

    logic       acc;
    t_action    act;
    logic [7:0] chr;

    logic [CNT_W-1:0]      cnt_m1;
    logic                  last_star;
    logic                  star_apply;
    logic                  do_star;
    logic                  do_wr;

    // chain signals between cells; entry MAX_ELEMENTS is past the last cell
    logic [MAX_ELEMENTS:0]   init_c;
    logic [MAX_ELEMENTS:0]   fwd_c;
    logic [MAX_ELEMENTS:0]   eps_c;
    logic [MAX_ELEMENTS-1:0] star_vec;
    logic [MAX_ELEMENTS:0]   cur_vec;
    logic                    verdict;

    t_cell_ctrl cell_ctrl [MAX_ELEMENTS];

    // Accept whenever the verdict register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign act           = t_action'(s_axis_tuser);
    assign chr           = s_axis_tdata;

    // ---------------------------------------------------------------
    // Pattern loading decisions
    // ---------------------------------------------------------------
    assign cnt_m1     = r_count - CNT_W'(1);
    assign last_star  = star_vec[cnt_m1[IDX_W-1:0]];
    // A star following an unstarred element marks it; any other star is a literal
    assign star_apply = (chr == STAR_CHAR) && (r_count != '0) && !last_star;
    assign do_star    = acc && (act == ACT_PATTERN) && !r_ovf && star_apply;
    assign do_wr      = acc && (act == ACT_PATTERN) && !r_ovf && !star_apply
                        && (r_count < CNT_W'(MAX_ELEMENTS));

    // ---------------------------------------------------------------
    // Cell row: each cell holds one element and its NFA position bit
    // ---------------------------------------------------------------
    assign init_c[0] = 1'b1;   // fresh subject starts at position zero
    assign fwd_c[0]  = 1'b0;
    assign eps_c[0]  = 1'b0;

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        always_comb begin
            cell_ctrl[g].clr      = acc && (act == ACT_CLEAR);
            cell_ctrl[g].wr       = do_wr && (r_count == CNT_W'(g));
            cell_ctrl[g].star_set = do_star && (cnt_m1 == CNT_W'(g));
            cell_ctrl[g].step     = acc && (act == ACT_SUBJECT);
            cell_ctrl[g].open     = r_open;
            cell_ctrl[g].chr      = chr;
        end

        wsp_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (cell_ctrl[g]),
            .i_init (init_c[g]),
            .i_fwd  (fwd_c[g]),
            .i_eps  (eps_c[g]),
            .o_init (init_c[g+1]),
            .o_fwd  (fwd_c[g+1]),
            .o_eps  (eps_c[g+1]),
            .o_star (star_vec[g]),
            .o_cur  (cur_vec[g])
        );
    end

    // Final position: held here since no element sits past it
    assign cur_vec[MAX_ELEMENTS] = r_open ? r_act_end : init_c[MAX_ELEMENTS];
    // Match when the position after the last loaded element is reached and the pattern has not overflowed
    assign verdict = cur_vec[r_count] && !r_ovf;

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_open        = r_open;
        n_act_end     = r_act_end;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_matched = r_out_matched;
        n_out_ovf     = r_out_ovf;

        if (acc) begin
            unique case (act)
                ACT_CLEAR: begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_open  = 1'b0;
                end
                ACT_PATTERN: begin
                    // a new pattern byte closes any open subject
                    n_open = 1'b0;
                    if (do_wr) begin
                        n_count = r_count + CNT_W'(1);
                    end else if (!r_ovf && !star_apply) begin
                        n_ovf = 1'b1;
                    end
                end
                ACT_SUBJECT: begin
                    n_open    = 1'b1;
                    n_act_end = fwd_c[MAX_ELEMENTS] || eps_c[MAX_ELEMENTS];
                end
                ACT_END: begin
                    n_open        = 1'b0;
                    n_out_valid   = 1'b1;
                    n_out_matched = verdict;
                    n_out_ovf     = r_ovf;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_open      <= 1'b0;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_open      <= n_open;
            r_act_end   <= n_act_end;
            r_out_valid <= n_out_valid;
        end
    end

    // verdict payload, no reset
    always_ff @(posedge i_clk) begin
        r_out_matched <= n_out_matched;
        r_out_ovf     <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_matched};
    assign m_axis_tuser  = r_out_ovf;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond store");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(MAX_ELEMENTS)))
        else $error("overflow set with free elements");

    a_no_match_on_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tuser))
        else $error("match reported with overflow");

    a_end_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (act == ACT_END)) |=> (m_axis_tvalid && !r_open))
        else $error("end transfer gave no verdict");

endmodule

### hw/rtl/wsp_cell.sv
module wsp_cell
    import wsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_init,   // start state reaches this position
    input  logic       i_fwd,    // left neighbor consumed its element
    input  logic       i_eps,    // left neighbor passes closure over its star
    output logic       o_init,
    output logic       o_fwd,
    output logic       o_eps,
    output logic       o_star,
    output logic       o_cur     // position active before this byte
);

    logic [7:0] r_char;
    logic       r_star;
    logic       r_used;
    logic       r_act;

    logic cur;
    logic hit;
    logic cl;

    always_comb begin
        cur    = i_ctrl.open ? r_act : i_init;
        hit    = r_used && cur && ((r_char == DOT_CHAR) || (r_char == i_ctrl.chr));
        cl     = (hit && r_star) || i_fwd || i_eps;
        o_init = i_init && r_star;
        o_fwd  = hit && !r_star;
        o_eps  = cl && r_star;
        o_star = r_star;
        o_cur  = cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star <= 1'b0;
            r_used <= 1'b0;
            r_act  <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_star <= 1'b0;
                r_used <= 1'b0;
            end else if (i_ctrl.wr) begin
                r_star <= 1'b0;
                r_used <= 1'b1;
            end else if (i_ctrl.star_set) begin
                r_star <= 1'b1;
            end
            if (i_ctrl.step) begin
                r_act <= cl;
            end
        end
    end

    // element byte, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_char <= i_ctrl.chr;
        end
    end

endmodule
